FILE: rtl/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned DEFAULT_STORE_DEPTH = 256;
	localparam logic [15:0] PAUSE_THRESHOLD_RESET = 16'd937;
	localparam logic [15:0] START_MIN = 16'd15;
	localparam int unsigned TIME_SHIFT = 3;

	localparam logic [2:0] MODE_EDGE = 3'd0;
	localparam logic [2:0] MODE_OVERFLOW = 3'd1;
	localparam logic [2:0] MODE_ARM = 3'd2;
	localparam logic [2:0] MODE_RD_SAMPLE = 3'd3;
	localparam logic [2:0] MODE_RD_PACKET = 3'd4;

	typedef struct packed {
		logic [15:0] read_data;
		logic [7:0] stored_count;
		logic [1:0] packet_number;
		logic waiting_for_start;
		logic capture_done;
		logic overrun;
	} result_t;

endpackage

FILE: rtl/ptc_if.sv
interface ptc_item_if;
	logic valid;
	logic ready;
	logic [2:0] mode;
	logic [15:0] timer_value;
	logic [7:0] address;

	modport source (output valid, mode, timer_value, address, input ready);
	modport sink (input valid, mode, timer_value, address, output ready);
endinterface

interface ptc_result_if;
	logic valid;
	logic ready;
	logic [15:0] read_data;
	logic [7:0] stored_count;
	logic [1:0] packet_number;
	logic waiting_for_start;
	logic capture_done;
	logic overrun;

	modport source (output valid, read_data, stored_count, packet_number,
		waiting_for_start, capture_done, overrun, input ready);
	modport sink (input valid, read_data, stored_count, packet_number,
		waiting_for_start, capture_done, overrun, output ready);
endinterface

interface ptc_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/ptc_store.sv
module ptc_store #(
	parameter int unsigned STORE_DEPTH = ptc_pkg::DEFAULT_STORE_DEPTH
) (
	input logic clk,
	input logic we,
	input logic [$clog2(STORE_DEPTH)-1:0] waddr,
	input logic [15:0] wdata,
	input logic re,
	input logic [$clog2(STORE_DEPTH)-1:0] raddr,
	output logic [15:0] rdata
);

	logic [15:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ptc_ctrl.sv
module ptc_ctrl #(
	parameter int unsigned STORE_DEPTH = ptc_pkg::DEFAULT_STORE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [2:0] mode,
	input logic [15:0] timer_value,
	input logic [7:0] address,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	output logic mem_we,
	output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
	output logic [15:0] mem_wdata,
	output logic mem_re,
	output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
	output ptc_pkg::result_t result,
	output logic sample_read
);
	import ptc_pkg::*;

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic [15:0] threshold_q;
	logic [7:0] ovf_q;
	logic pol_q;
	logic armed_q;
	logic stopped_q;
	logic overfull_q;
	logic [AW-1:0] cnt_q;
	logic [15:0] eip_q;
	logic [1:0] pidx_q;
	logic [15:0] pec_q [4];

	logic [7:0] ovf_inc;
	logic ovf_edge;
	logic do_edge;
	logic [7:0] ovf_use;
	logic [15:0] timer_eff;
	logic [23:0] raw;
	logic [15:0] dur;
	logic start;
	logic rec;
	logic store_ok;
	logic close;
	logic in_range;

	logic [7:0] ovf_d;
	logic pol_d;
	logic armed_d;
	logic stopped_d;
	logic overfull_d;
	logic [AW-1:0] cnt_d;
	logic [15:0] eip_d;
	logic [1:0] pidx_d;
	logic [15:0] pec_d [4];

	always_comb begin
		ovf_inc = ovf_q + 8'd1;
		ovf_edge = (mode == MODE_OVERFLOW) && (ovf_inc > 8'd1);
		do_edge = (mode == MODE_EDGE) || ovf_edge;
		ovf_use = (mode == MODE_OVERFLOW) ? ovf_inc : ovf_q;
		timer_eff = (mode == MODE_EDGE) ? timer_value : 16'd0;
		raw = {ovf_use, timer_eff};
		dur = 16'(raw >> TIME_SHIFT);

		ovf_d = ovf_q;
		pol_d = pol_q;
		armed_d = armed_q;
		stopped_d = stopped_q;
		overfull_d = overfull_q;
		cnt_d = cnt_q;
		eip_d = eip_q;
		pidx_d = pidx_q;
		pec_d = pec_q;
		start = 1'b0;
		rec = 1'b0;
		store_ok = 1'b0;
		close = 1'b0;

		if (mode == MODE_OVERFLOW) begin
			ovf_d = ovf_inc;
			if (ovf_edge) begin
				overfull_d = 1'b1;
			end
		end
		if (mode == MODE_ARM) begin
			armed_d = 1'b1;
		end

		if (do_edge) begin
			pol_d = ~pol_q;
			ovf_d = 8'd0;
			// pulse when armed, the previous edge left the line active and the duration exceeds START_MIN
			start = armed_q && pol_q && (dur > START_MIN);
			if (start) begin
				armed_d = 1'b0;
				stopped_d = 1'b0;
				overfull_d = 1'b0;
				cnt_d = '0;
				eip_d = 16'd0;
				pidx_d = 2'd0;
				for (int i = 0; i < 4; i++) begin
					pec_d[i] = 16'd0;
				end
			end
			rec = !stopped_d && !armed_d;
			if (rec) begin
				store_ok = cnt_d < AW'(STORE_DEPTH - 1);
				if (store_ok) begin
					cnt_d = cnt_d + AW'(1);
				end
				eip_d = eip_d + 16'd1;
				close = !pol_q && (dur > threshold_q);
				if (close) begin
					pec_d[pidx_d] = eip_d;
					eip_d = 16'd0;
					if (pidx_d == 2'd3 || overfull_d) begin
						stopped_d = 1'b1;
					end else begin
						pidx_d = pidx_d + 2'd1;
					end
				end
			end
		end
	end

	// write address is the count before this beat, after a start pulse resets it
	assign mem_we = accept && rec && store_ok;
	assign mem_waddr = start ? '0 : cnt_q;
	assign mem_wdata = dur;

	assign in_range = 32'(address) < 32'(STORE_DEPTH);
	assign sample_read = (mode == MODE_RD_SAMPLE) && in_range;
	assign mem_re = accept && sample_read;
	assign mem_raddr = AW'(address);

	always_comb begin
		result.read_data = (mode == MODE_RD_PACKET) ? pec_q[address[1:0]] : 16'd0;
		result.stored_count = 8'(cnt_d);
		result.packet_number = pidx_d;
		result.waiting_for_start = armed_d;
		result.capture_done = stopped_d;
		result.overrun = overfull_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= PAUSE_THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 8'd0;
			pol_q <= 1'b0;
			armed_q <= 1'b0;
			stopped_q <= 1'b0;
			overfull_q <= 1'b0;
			cnt_q <= '0;
			eip_q <= 16'd0;
			pidx_q <= 2'd0;
			for (int i = 0; i < 4; i++) begin
				pec_q[i] <= 16'd0;
			end
		end else if (accept) begin
			ovf_q <= ovf_d;
			pol_q <= pol_d;
			armed_q <= armed_d;
			stopped_q <= stopped_d;
			overfull_q <= overfull_d;
			cnt_q <= cnt_d;
			eip_q <= eip_d;
			pidx_q <= pidx_d;
			pec_q <= pec_d;
		end
	end

endmodule

FILE: rtl/ir_pulse_train_capture.sv
// Infrared pulse-train capture. One item is accepted per clock cycle, back to back, unless
// the result side stalls; each item gives one result through the stage register and the
// output register. Capture state is updated in the accept cycle, durations are written to
// a single-port-write sample memory at the same edge, and a sample read returns the memory's
// registered read data, so a read always sees every earlier write. A stalled result is
// held in an output register while one more item waits in the stage behind it. The pause
// threshold may be rewritten only while the block is idle; it resets to 937.
module ir_pulse_train_capture #(
	parameter int unsigned STORE_DEPTH = ptc_pkg::DEFAULT_STORE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	ptc_item_if.sink item,
	ptc_result_if.source result,
	ptc_cfg_if.sink cfg
);
	import ptc_pkg::*;

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic accept;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0] mem_rdata;
	result_t res_c;
	logic sample_read_c;

	logic v_s1;
	result_t res_s1;
	logic sample_read_s1;
	logic out_v_q;
	result_t out_q;
	logic adv;

	assign adv = v_s1 && (!out_v_q || result.ready);
	assign item.ready = !v_s1 || adv;
	assign accept = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	ptc_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.mode(item.mode),
		.timer_value(item.timer_value),
		.address(item.address),
		.cfg_we(cfg.valid),
		.cfg_data(cfg.data),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.result(res_c),
		.sample_read(sample_read_c)
	);

	ptc_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_c;
			sample_read_s1 <= sample_read_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// read data of the memory holds until the next accepted beat, which cannot pass adv
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.read_data <= sample_read_s1 ? mem_rdata : res_s1.read_data;
			out_q.stored_count <= res_s1.stored_count;
			out_q.packet_number <= res_s1.packet_number;
			out_q.waiting_for_start <= res_s1.waiting_for_start;
			out_q.capture_done <= res_s1.capture_done;
			out_q.overrun <= res_s1.overrun;
		end
	end

	assign result.valid = out_v_q;
	assign result.read_data = out_q.read_data;
	assign result.stored_count = out_q.stored_count;
	assign result.packet_number = out_q.packet_number;
	assign result.waiting_for_start = out_q.waiting_for_start;
	assign result.capture_done = out_q.capture_done;
	assign result.overrun = out_q.overrun;

endmodule
